// ===== design/drmt_pkg.sv =====
// shared constants and types for the dirty rectangle merge tracker
// no dependencies
`timescale 1ns / 1ps

package drmt_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int COORD_BITS  = 10;
  localparam int SLACK_BITS  = 4;
  localparam int IN_BITS     = 16;
  localparam int IDX_BITS    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_DISP_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DISP_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_TOP_MARGIN  = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_MERGE_SLACK = 2'd3;

  localparam logic [COORD_BITS-1:0] RESET_WIDTH  = COORD_BITS'(240);
  localparam logic [COORD_BITS-1:0] RESET_HEIGHT = COORD_BITS'(320);
  localparam logic [COORD_BITS-1:0] RESET_MARGIN = COORD_BITS'(30);
  localparam logic [SLACK_BITS-1:0] RESET_SLACK  = SLACK_BITS'(2);

  localparam logic OP_MARK  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef struct packed {
    logic [COORD_BITS-1:0] span_y;
    logic [COORD_BITS-1:0] span_x;
    logic [COORD_BITS-1:0] top;
    logic [COORD_BITS-1:0] left;
  } rect_t;

  localparam int RECT_BITS = $bits(rect_t);

  typedef struct packed {
    logic [COORD_BITS-1:0] disp_width;
    logic [COORD_BITS-1:0] disp_height;
    logic [COORD_BITS-1:0] top_margin;
  } geom_t;

endpackage

// ===== design/drmt_ram.sv =====
// generic simple dual port ram, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps

module drmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]               wdata,
  input  logic                           re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/drmt_clamp.sv =====
// rejects and clamps an incoming rectangle to the drawable band, registered result
// depends on drmt_pkg
`timescale 1ns / 1ps

module drmt_clamp (
  input  logic                                clk,
  input  logic                                load,
  input  drmt_pkg::geom_t                     geom,
  input  logic signed [drmt_pkg::IN_BITS-1:0] x,
  input  logic signed [drmt_pkg::IN_BITS-1:0] y,
  input  logic signed [drmt_pkg::IN_BITS-1:0] w,
  input  logic signed [drmt_pkg::IN_BITS-1:0] h,
  output logic                                ok,
  output drmt_pkg::rect_t                     rect
);

  localparam int WB = drmt_pkg::IN_BITS + 2;

  logic signed [WB-1:0] xs, ys, ws, hs, xe, ye;
  logic signed [WB-1:0] lim_w, lim_h, lim_t;
  logic signed [WB-1:0] x1, x2, y1, y2, dx, dy;
  logic                 reject;

  function automatic logic signed [WB-1:0] clampv(
    input logic signed [WB-1:0] v,
    input logic signed [WB-1:0] lo,
    input logic signed [WB-1:0] hi
  );
    logic signed [WB-1:0] r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  always_comb begin
    xs    = WB'(x);
    ys    = WB'(y);
    ws    = WB'(w);
    hs    = WB'(h);
    xe    = xs + ws;
    ye    = ys + hs;
    lim_w = WB'({1'b0, geom.disp_width});
    lim_h = WB'({1'b0, geom.disp_height});
    lim_t = WB'({1'b0, geom.top_margin});
    x1    = clampv(xs, '0, lim_w);
    x2    = clampv(xe, '0, lim_w);
    y1    = clampv(ys, lim_t, lim_h);
    y2    = clampv(ye, lim_t, lim_h);
    dx    = x2 - x1;
    dy    = y2 - y1;
    reject = (ws <= 0) || (hs <= 0) || (xs >= lim_w) || (ys >= lim_h) ||
             (xe <= 0) || (ye <= lim_t) || (x2 <= x1) || (y2 <= y1);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ok          <= !reject;
      rect.left   <= x1[drmt_pkg::COORD_BITS-1:0];
      rect.top    <= y1[drmt_pkg::COORD_BITS-1:0];
      rect.span_x <= dx[drmt_pkg::COORD_BITS-1:0];
      rect.span_y <= dy[drmt_pkg::COORD_BITS-1:0];
    end
  end

endmodule

// ===== design/dirty_rect_merge_tracker.sv =====
// top level: region table control, merge scan, drain sequencing, config registers
// depends on drmt_pkg, drmt_ram, drmt_clamp
`timescale 1ns / 1ps
// Dirty rectangle tracker with merging.
// Input items arrive on s_t*: tuser is the operation (0 mark, 1 drain), tdata holds
// left, top, span_x, span_y as 16-bit signed values from the lowest bit up.
// A mark is clamped to the drawable band and merged into the first stored region it
// touches (within merge_slack), appended otherwise, or sets a full-redraw flag when
// the table is full. A mark gives no result; it passes through a clamp state and then,
// if regions are stored, scans them in table order; the scan reads the region table
// ram one entry per cycle.
// A drain emits on m_t* each stored region in table order (tlast on the final one),
// or one full-band region when the flag is set, or one item with tuser
// (nothing_dirty) set and zero fields when the table is empty, then clears the table.
// A drain's first result is registered in the start state if the flag is set or the
// table is empty, else in the drain state, then one per cycle while m_tready is high;
// a stall on m_tready holds the output register and pauses the drain.
// One item is worked on at a time; s_tready is high only when idle.
// Config writes on cfg_* are always taken; write them only while idle.
// Reset clears the region count and flag and loads the default geometry and slack; ram
// contents are never read before they are written, so no clearing pass is needed.

module dirty_rect_merge_tracker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [63:0]                       s_tdata,  // left, top, span_x, span_y
  input  logic                              s_tuser,  // operation
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [39:0]                       m_tdata,  // left, top, span_x, span_y
  output logic                              m_tuser,  // nothing_dirty
  output logic                              m_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [drmt_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [drmt_pkg::COORD_BITS-1:0]   cfg_data
);

  localparam int CB = drmt_pkg::COORD_BITS;
  localparam int SB = CB + 2;
  localparam int IB = drmt_pkg::IDX_BITS;
  localparam int NB = drmt_pkg::CNT_BITS;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CLAMP  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DSTART = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;

  logic [2:0]    state;
  logic [IB-1:0] idx;
  logic [NB-1:0] count;
  logic          overflow;

  drmt_pkg::geom_t              geom;
  logic [drmt_pkg::SLACK_BITS-1:0] slack;

  logic            s_accept, out_free;
  logic            c_ok;
  drmt_pkg::rect_t c_rect, entry, merged;

  logic            ram_we, ram_re;
  logic [IB-1:0]   ram_waddr, ram_raddr;
  drmt_pkg::rect_t ram_wdata;

  logic            ovalid, olast, onone;
  drmt_pkg::rect_t orect;

  logic [SB-1:0] e_r, e_b, c_r, c_b, e_rs, e_bs, c_rs, c_bs;
  logic [SB-1:0] max_r, max_b, min_l, min_t;
  logic          touch, idx_last, full;
  logic [CB-1:0] ov_span_y;

  assign s_accept  = s_tvalid && s_tready;
  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !ovalid || m_tready;

  assign m_tvalid = ovalid;
  assign m_tdata  = {orect.span_y, orect.span_x, orect.top, orect.left};
  assign m_tuser  = onone;
  assign m_tlast  = olast;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      geom.disp_width  <= drmt_pkg::RESET_WIDTH;
      geom.disp_height <= drmt_pkg::RESET_HEIGHT;
      geom.top_margin  <= drmt_pkg::RESET_MARGIN;
      slack            <= drmt_pkg::RESET_SLACK;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        drmt_pkg::REG_DISP_WIDTH:  geom.disp_width  <= cfg_data;
        drmt_pkg::REG_DISP_HEIGHT: geom.disp_height <= cfg_data;
        drmt_pkg::REG_TOP_MARGIN:  geom.top_margin  <= cfg_data;
        drmt_pkg::REG_MERGE_SLACK: slack <= cfg_data[drmt_pkg::SLACK_BITS-1:0];
        default: ;
      endcase
    end
  end

  drmt_clamp u_clamp (
    .clk  (clk),
    .load (s_accept && (s_tuser == drmt_pkg::OP_MARK)),
    .geom (geom),
    .x    (s_tdata[15:0]),
    .y    (s_tdata[31:16]),
    .w    (s_tdata[47:32]),
    .h    (s_tdata[63:48]),
    .ok   (c_ok),
    .rect (c_rect)
  );

  drmt_ram #(
    .WIDTH (drmt_pkg::RECT_BITS),
    .DEPTH (drmt_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (entry)
  );

  // touch test and bounding union against the entry read last cycle
  always_comb begin
    e_r   = SB'(entry.left) + SB'(entry.span_x);
    e_b   = SB'(entry.top) + SB'(entry.span_y);
    c_r   = SB'(c_rect.left) + SB'(c_rect.span_x);
    c_b   = SB'(c_rect.top) + SB'(c_rect.span_y);
    e_rs  = e_r + SB'(slack);
    e_bs  = e_b + SB'(slack);
    c_rs  = c_r + SB'(slack);
    c_bs  = c_b + SB'(slack);
    touch = (SB'(entry.left) <= c_rs) && (SB'(c_rect.left) <= e_rs) &&
            (SB'(entry.top) <= c_bs) && (SB'(c_rect.top) <= e_bs);
    max_r = (e_r > c_r) ? e_r : c_r;
    max_b = (e_b > c_b) ? e_b : c_b;
    min_l = (entry.left < c_rect.left) ? SB'(entry.left) : SB'(c_rect.left);
    min_t = (entry.top < c_rect.top) ? SB'(entry.top) : SB'(c_rect.top);
    merged.left   = min_l[CB-1:0];
    merged.top    = min_t[CB-1:0];
    merged.span_x = CB'(max_r - min_l);
    merged.span_y = CB'(max_b - min_t);
  end

  assign idx_last = ((NB'(idx) + NB'(1)) >= count);
  assign full     = (count >= NB'(drmt_pkg::TABLE_DEPTH));
  assign ov_span_y = (geom.disp_height > geom.top_margin) ?
                     (geom.disp_height - geom.top_margin) : '0;

  // ram port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = c_rect;
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state)
      S_CLAMP: begin
        if (c_ok && (count == '0)) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
        end else if (c_ok) begin
          ram_re = 1'b1;
        end
      end
      S_SCAN: begin
        if (touch) begin
          ram_we    = 1'b1;
          ram_wdata = merged;
        end else if (!idx_last) begin
          ram_re    = 1'b1;
          ram_raddr = idx + IB'(1);
        end else if (!full) begin
          ram_we    = 1'b1;
          ram_waddr = count[IB-1:0];
        end
      end
      S_DSTART: begin
        ram_re = !overflow && (count != '0);
      end
      S_DRAIN: begin
        if (out_free && !idx_last) begin
          ram_re    = 1'b1;
          ram_raddr = idx + IB'(1);
        end
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      overflow <= 1'b0;
      idx      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_accept) begin
            state <= (s_tuser == drmt_pkg::OP_DRAIN) ? S_DSTART : S_CLAMP;
          end
        end
        S_CLAMP: begin
          idx <= '0;
          if (!c_ok) begin
            state <= S_IDLE;
          end else if (count == '0) begin
            count <= NB'(1);
            state <= S_IDLE;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (touch) begin
            state <= S_IDLE;
          end else if (!idx_last) begin
            idx <= idx + IB'(1);
          end else begin
            if (full) begin
              overflow <= 1'b1;
            end else begin
              count <= count + NB'(1);
            end
            state <= S_IDLE;
          end
        end
        S_DSTART: begin
          idx <= '0;
          if (overflow || (count == '0)) begin
            if (out_free) begin
              overflow <= 1'b0;
              count    <= '0;
              state    <= S_IDLE;
            end
          end else begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (out_free) begin
            if (idx_last) begin
              count <= '0;
              state <= S_IDLE;
            end else begin
              idx <= idx + IB'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (out_free) begin
      ovalid <= ((state == S_DSTART) && (overflow || (count == '0))) ||
                (state == S_DRAIN);
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (state == S_DRAIN) begin
        orect <= entry;
        onone <= 1'b0;
        olast <= idx_last;
      end else if (overflow) begin
        orect.left   <= '0;
        orect.top    <= geom.top_margin;
        orect.span_x <= geom.disp_width;
        orect.span_y <= ov_span_y;
        onone        <= 1'b0;
        olast        <= 1'b1;
      end else begin
        orect <= '0;
        onone <= 1'b1;
        olast <= 1'b1;
      end
    end
  end

endmodule

// ===== sim/testbench.sv =====
// testbench for dirty_rect_merge_tracker: directed and random marks and drains,
// checked against an in-bench model of the region table, under varied handshake pressure
// depends on drmt_pkg and the tracker rtl
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [drmt_pkg::COORD_BITS-1:0] left;
    logic [drmt_pkg::COORD_BITS-1:0] top;
    logic [drmt_pkg::COORD_BITS-1:0] span_x;
    logic [drmt_pkg::COORD_BITS-1:0] span_y;
    logic                            none;
    logic                            last;
  } region_item_t;

  logic                              clk;
  logic                              rst;
  logic                              s_tvalid;
  logic                              s_tready;
  logic [63:0]                       s_tdata;
  logic                              s_tuser;
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  logic [39:0]                       m_tdata;
  logic                              m_tuser;
  logic                              m_tlast;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [drmt_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [drmt_pkg::COORD_BITS-1:0]   cfg_data;

  // model of the region table and geometry registers
  int                              tbl_left [drmt_pkg::TABLE_DEPTH];
  int                              tbl_top  [drmt_pkg::TABLE_DEPTH];
  int                              tbl_sx   [drmt_pkg::TABLE_DEPTH];
  int                              tbl_sy   [drmt_pkg::TABLE_DEPTH];
  int                              stored_count;
  bit                              full_redraw;
  logic [drmt_pkg::COORD_BITS-1:0] scr_width;
  logic [drmt_pkg::COORD_BITS-1:0] scr_height;
  logic [drmt_pkg::COORD_BITS-1:0] top_mrg;
  logic [drmt_pkg::SLACK_BITS-1:0] slack;

  region_item_t pending_regions[$];
  int           errors;
  int           cycle_count = 0;
  int           send_idle;
  int           recv_stall;
  int           hold_len;
  int           held = 0;

  dirty_rect_merge_tracker i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: long hold-off when requested, random stalls otherwise
  always @(negedge clk) begin
    if (held < hold_len) begin
      held     <= held + 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  function automatic int clip(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void push_region(int l, int t, int sx, int sy, bit none, bit last);
    region_item_t r;
    r.left   = drmt_pkg::COORD_BITS'(l);
    r.top    = drmt_pkg::COORD_BITS'(t);
    r.span_x = drmt_pkg::COORD_BITS'(sx);
    r.span_y = drmt_pkg::COORD_BITS'(sy);
    r.none   = none;
    r.last   = last;
    pending_regions.push_back(r);
  endfunction

  function automatic void apply_mark(int x, int y, int w, int h);
    int wd, ht, tm, sl, x1, y1, x2, y2, r, b;
    wd = int'(scr_width);
    ht = int'(scr_height);
    tm = int'(top_mrg);
    sl = int'(slack);
    if (w <= 0 || h <= 0 || x >= wd || y >= ht || x + w <= 0 || y + h <= tm) return;
    x1 = clip(x, 0, wd);
    y1 = clip(y, tm, ht);
    x2 = clip(x + w, 0, wd);
    y2 = clip(y + h, tm, ht);
    if (x2 <= x1 || y2 <= y1) return;
    for (int i = 0; i < stored_count; i++) begin
      if (tbl_left[i] <= x2 + sl && x1 <= tbl_left[i] + tbl_sx[i] + sl &&
          tbl_top[i] <= y2 + sl && y1 <= tbl_top[i] + tbl_sy[i] + sl) begin
        r = (tbl_left[i] + tbl_sx[i] > x2) ? tbl_left[i] + tbl_sx[i] : x2;
        b = (tbl_top[i] + tbl_sy[i] > y2) ? tbl_top[i] + tbl_sy[i] : y2;
        tbl_left[i] = (tbl_left[i] < x1) ? tbl_left[i] : x1;
        tbl_top[i]  = (tbl_top[i] < y1) ? tbl_top[i] : y1;
        tbl_sx[i]   = r - tbl_left[i];
        tbl_sy[i]   = b - tbl_top[i];
        return;
      end
    end
    if (stored_count < drmt_pkg::TABLE_DEPTH) begin
      tbl_left[stored_count] = x1;
      tbl_top[stored_count]  = y1;
      tbl_sx[stored_count]   = x2 - x1;
      tbl_sy[stored_count]   = y2 - y1;
      stored_count++;
    end else begin
      full_redraw = 1'b1;
    end
  endfunction

  function automatic void predict_drain();
    int ht, tm;
    ht = int'(scr_height);
    tm = int'(top_mrg);
    if (full_redraw) begin
      push_region(0, tm, int'(scr_width), (ht > tm) ? ht - tm : 0, 1'b0, 1'b1);
    end else if (stored_count == 0) begin
      push_region(0, 0, 0, 0, 1'b1, 1'b1);
    end else begin
      for (int i = 0; i < stored_count; i++)
        push_region(tbl_left[i], tbl_top[i], tbl_sx[i], tbl_sy[i], 1'b0,
                    i + 1 == stored_count);
    end
    stored_count = 0;
    full_redraw  = 1'b0;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t mismatch on %s: expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    region_item_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_regions.size() == 0) begin
        $display("%0t unexpected region item: expected none, got %h none=%b last=%b",
                 $time, m_tdata, m_tuser, m_tlast);
        errors++;
      end else begin
        want = pending_regions.pop_front();
        check_field("region_left",   want.left,   m_tdata[9:0]);
        check_field("region_top",    want.top,    m_tdata[19:10]);
        check_field("region_span_x", want.span_x, m_tdata[29:20]);
        check_field("region_span_y", want.span_y, m_tdata[39:30]);
        check_field("nothing_dirty", want.none,   m_tuser);
        check_field("last_region",   want.last,   m_tlast);
      end
    end
  end

  task automatic offer_item(input logic op, input logic signed [15:0] l,
                            input logic signed [15:0] t, input logic signed [15:0] w,
                            input logic signed [15:0] h);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {h, w, t, l};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (op == drmt_pkg::OP_DRAIN) predict_drain();
    else apply_mark(int'(l), int'(t), int'(w), int'(h));
  endtask

  task automatic mark(input int l, input int t, input int w, input int h);
    offer_item(drmt_pkg::OP_MARK, 16'(l), 16'(t), 16'(w), 16'(h));
  endtask

  task automatic drain();
    offer_item(drmt_pkg::OP_DRAIN, 16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom));
  endtask

  // stop offering, wait for every region, then let any mark scan finish
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_regions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [drmt_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [drmt_pkg::COORD_BITS-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      drmt_pkg::REG_DISP_WIDTH:  scr_width  = value;
      drmt_pkg::REG_DISP_HEIGHT: scr_height = value;
      drmt_pkg::REG_TOP_MARGIN:  top_mrg    = value;
      drmt_pkg::REG_MERGE_SLACK: slack      = value[drmt_pkg::SLACK_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_geometry(input int wd, input int ht, input int tm, input int sl);
    wait_idle();
    write_reg(drmt_pkg::REG_DISP_WIDTH, 10'(wd));
    write_reg(drmt_pkg::REG_DISP_HEIGHT, 10'(ht));
    write_reg(drmt_pkg::REG_TOP_MARGIN, 10'(tm));
    write_reg(drmt_pkg::REG_MERGE_SLACK, 10'(sl));
  endtask

  task automatic test_directed_marks();
    drain();
    mark(5, 40, 0, 10);
    mark(5, 40, 10, -1);
    mark(240, 40, 5, 5);
    mark(0, 320, 5, 5);
    mark(-10, 40, 10, 5);
    mark(0, 0, 5, 30);
    drain();
    mark(-32768, -32768, 32767, 32767);
    mark(-100, -100, 32767, 32767);
    mark(32767, 32767, 32767, 32767);
    mark(-32768, -32768, -32768, -32768);
    drain();
    mark(10, 40, 20, 20);
    mark(32, 40, 5, 5);
    mark(100, 40, 5, 5);
    mark(40, 63, 5, 5);
    mark(102, 47, 3, 3);
    mark(230, 310, 50, 50);
    drain();
    wait_idle();
  endtask

  task automatic test_table_overflow();
    for (int i = 0; i < 36; i++)
      mark((i % 8) * 28, 30 + (i / 8) * 28, 4, 4);
    mark(6, 30, 4, 4);
    drain();
    for (int i = 0; i < 33; i++)
      mark((i % 8) * 28, 30 + (i / 8) * 28, 4, 4);
    set_geometry(240, 320, 400, 2);
    mark(0, 0, 100, 1000);
    drain();
    set_geometry(240, 320, 30, 2);
  endtask

  task automatic test_config_extremes();
    set_geometry(1, 1023, 0, 0);
    mark(0, 0, 1, 1023);
    mark(-5, -5, 100, 2000);
    mark(0, 500, 1, 1);
    drain();
    set_geometry(1023, 1023, 1023, 10'h3ff);
    mark(0, 0, 500, 2000);
    drain();
    set_geometry(0, 0, 0, 10'h3f0);
    mark(0, 0, 10, 10);
    mark(-5, -5, 10, 10);
    drain();
    set_geometry(1023, 1023, 0, 15);
    mark(1000, 1000, 100, 100);
    mark(0, 0, 1, 1);
    mark(16, 0, 1, 1);
    mark(0, 17, 1, 1);
    drain();
    wait_idle();
  endtask

  task automatic test_backpressure();
    set_geometry(240, 320, 30, 2);
    for (int i = 0; i < 6; i++)
      mark(i * 30, 40, 10, 10);
    hold_len = 400;
    drain();
    for (int i = 0; i < 4; i++)
      mark(i * 40, 100, 8, 8);
    drain();
    mark(5, 200, 20, 20);
    drain();
    wait_idle();
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int quota);
    int wd, ht, tm, l, t, sw, sh, marks, taken;
    taken = 0;
    wait_idle();
    send_idle  = idle_pct;
    recv_stall = stall_pct;
    ht = $urandom_range(1023, 16);
    wd = $urandom_range(1) ? $urandom_range(1023, 16) : $urandom_range(200, 16);
    tm = $urandom_range(ht / 2);
    write_reg(drmt_pkg::REG_DISP_WIDTH, 10'(wd));
    write_reg(drmt_pkg::REG_DISP_HEIGHT, 10'(ht));
    write_reg(drmt_pkg::REG_TOP_MARGIN, 10'(tm));
    write_reg(drmt_pkg::REG_MERGE_SLACK, 10'($urandom));
    while (taken < quota) begin
      case ($urandom_range(9))
        0:       marks = 0;
        1, 2:    marks = $urandom_range(40, 20);
        default: marks = $urandom_range(8, 1);
      endcase
      for (int k = 0; k < marks && taken < quota; k++) begin
        if ($urandom_range(9) < 8) begin
          l  = int'($urandom_range(wd + 8)) - 10;
          t  = tm - 10 + int'($urandom_range(ht - tm + 8));
          sw = ($urandom_range(3) == 0) ? $urandom_range(300, 1) : $urandom_range(40, 1);
          sh = ($urandom_range(3) == 0) ? $urandom_range(300, 1) : $urandom_range(40, 1);
          mark(l, t, sw, sh);
        end else begin
          mark($urandom, $urandom, $urandom, $urandom);
        end
        taken++;
      end
      drain();
      taken++;
    end
  endtask

  task automatic test_random_traffic();
    run_phase(0, 0, 22);
    run_phase(88, 0, 22);
    run_phase(0, 88, 22);
    run_phase(27, 27, 22);
    send_idle  = 0;
    recv_stall = 0;
    wait_idle();
  endtask

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    errors       = 0;
    send_idle    = 0;
    recv_stall   = 0;
    hold_len     = 0;
    stored_count = 0;
    full_redraw  = 1'b0;
    scr_width    = drmt_pkg::RESET_WIDTH;
    scr_height   = drmt_pkg::RESET_HEIGHT;
    top_mrg      = drmt_pkg::RESET_MARGIN;
    slack        = drmt_pkg::RESET_SLACK;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_marks();
    test_table_overflow();
    test_config_extremes();
    test_backpressure();
    test_random_traffic();

    if (pending_regions.size() != 0) begin
      $display("%0t regions still expected: expected 0, got %0d", $time,
               pending_regions.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
